/* hdl/bnts_pkg.sv */
// ----------------------------------------------------------------------------
// bnts_pkg
// Shared types and constants of the buzzer note tone sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bnts_pkg;

    localparam int NUM_W   = 20;
    localparam int TEMPO_W = 10;
    localparam int GAP_W   = 8;
    localparam int TPM_W   = 10;
    localparam int FREQ_W  = 12;
    localparam int BEATS_W = 4;
    localparam int HALF_W  = 16;
    localparam int MS_W    = 14;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [NUM_W-1:0]   NUM_RESET   = NUM_W'(500000);
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(300);
    localparam logic [GAP_W-1:0]   GAP_RESET   = GAP_W'(30);
    localparam logic [TPM_W-1:0]   TPM_RESET   = TPM_W'(1000);

    localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TPM       = 2'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_NOTE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_NOTE,
        PH_GAP
    } phase_t;

    typedef enum logic {
        F_IDLE,
        F_DIV
    } front_state_t;

    typedef struct packed {
        logic                is_note;
        logic                freq_nz;
        logic [HALF_W-1:0]   half;
        logic [BEATS_W-1:0]  beats;
    } tone_cmd_t;

    typedef struct packed {
        logic      push;
        tone_cmd_t cmd;
    } queue_push_t;

endpackage

`default_nettype wire

/* hdl/bnts_front.sv */
// ----------------------------------------------------------------------------
// bnts_front
// Accepts input words, computes the half period of tone notes with a
// serial divider and pushes decoded commands into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bnts_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              opcode,
    input  wire logic [bnts_pkg::FREQ_W-1:0]       note_freq,
    input  wire logic [bnts_pkg::BEATS_W-1:0]      note_beats,
    input  wire logic [bnts_pkg::NUM_W-1:0]        numerator,
    input  wire logic                              queue_full,
    output bnts_pkg::queue_push_t                  push_o
);

    localparam int STEP_W = $clog2(bnts_pkg::NUM_W + 1);

    bnts_pkg::front_state_t state_reg, state_next;

    logic [STEP_W-1:0]              step_reg, step_next;
    logic [bnts_pkg::NUM_W-1:0]     num_reg, num_next;
    logic [bnts_pkg::FREQ_W-1:0]    rem_reg, rem_next;
    logic [bnts_pkg::FREQ_W-1:0]    freq_reg, freq_next;
    logic [bnts_pkg::BEATS_W-1:0]   beats_reg, beats_next;

    logic                           accept;
    logic                           start_div;
    logic [bnts_pkg::FREQ_W:0]      trial;
    logic                           ge;
    logic [bnts_pkg::FREQ_W:0]      diff;
    logic [bnts_pkg::HALF_W-1:0]    half_sat;

    assign accept    = in_valid && !in_stall;
    assign start_div = accept && (opcode == bnts_pkg::OP_NOTE) && (note_freq != '0);

    assign trial = {rem_reg, num_reg[bnts_pkg::NUM_W-1]};
    assign ge    = trial >= {1'b0, freq_reg};
    assign diff  = trial - {1'b0, freq_reg};

    always_comb
    begin
        if (num_reg[bnts_pkg::NUM_W-1:bnts_pkg::HALF_W] != '0)
        begin
            half_sat = '1;
        end
        else if (num_reg[bnts_pkg::HALF_W-1:0] == '0)
        begin
            half_sat = bnts_pkg::HALF_W'(1);
        end
        else
        begin
            half_sat = num_reg[bnts_pkg::HALF_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bnts_pkg::F_IDLE:
            begin
                if (start_div)
                begin
                    state_next = bnts_pkg::F_DIV;
                end
            end
            bnts_pkg::F_DIV:
            begin
                if ((step_reg == '0) && !queue_full)
                begin
                    state_next = bnts_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = bnts_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        push_o      = '0;
        step_next   = step_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        freq_next   = freq_reg;
        beats_next  = beats_reg;
        case (state_reg)
            bnts_pkg::F_IDLE:
            begin
                in_stall = queue_full;
                if (start_div)
                begin
                    step_next  = STEP_W'(bnts_pkg::NUM_W);
                    num_next   = numerator;
                    rem_next   = '0;
                    freq_next  = note_freq;
                    beats_next = note_beats;
                end
                else if (accept)
                begin
                    push_o.push          = 1'b1;
                    push_o.cmd.is_note   = opcode;
                    push_o.cmd.freq_nz   = 1'b0;
                    push_o.cmd.half      = '0;
                    push_o.cmd.beats     = note_beats;
                end
            end
            bnts_pkg::F_DIV:
            begin
                if (step_reg != '0)
                begin
                    step_next = step_reg - STEP_W'(1);
                    num_next  = {num_reg[bnts_pkg::NUM_W-2:0], ge};
                    rem_next  = ge ? diff[bnts_pkg::FREQ_W-1:0]
                                   : trial[bnts_pkg::FREQ_W-1:0];
                end
                else if (!queue_full)
                begin
                    push_o.push        = 1'b1;
                    push_o.cmd.is_note = 1'b1;
                    push_o.cmd.freq_nz = 1'b1;
                    push_o.cmd.half    = half_sat;
                    push_o.cmd.beats   = beats_reg;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bnts_pkg::F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        freq_reg  <= freq_next;
        beats_reg <= beats_next;
    end

endmodule

`default_nettype wire

/* hdl/bnts_queue.sv */
// ----------------------------------------------------------------------------
// bnts_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bnts_queue #(
    parameter int DEPTH = bnts_pkg::QUEUE_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bnts_pkg::queue_push_t push_i,
    input  wire logic                  pop,
    output bnts_pkg::tone_cmd_t        head,
    output logic                       empty,
    output logic                       full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bnts_pkg::tone_cmd_t slot_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push_i.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_i.cmd;
        end
    end

endmodule

`default_nettype wire

/* hdl/bnts_back.sv */
// ----------------------------------------------------------------------------
// bnts_back
// Carries out queued commands: tone toggling, millisecond timing, note and
// gap phases, and holds the result word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bnts_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bnts_pkg::tone_cmd_t            head,
    input  wire logic                           empty,
    output logic                                pop,
    input  wire logic [bnts_pkg::TEMPO_W-1:0]   beat_ms,
    input  wire logic [bnts_pkg::GAP_W-1:0]     gap_ms,
    input  wire logic [bnts_pkg::TPM_W-1:0]     ticks_per_ms,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                buzzer_level,
    output logic                                busy_res,
    output logic                                note_done
);

    bnts_pkg::phase_t phase_reg, phase_next;

    logic [bnts_pkg::HALF_W-1:0] half_reload_reg, half_reload_next;
    logic [bnts_pkg::HALF_W-1:0] half_cnt_reg, half_cnt_next;
    logic                        sounding_reg, sounding_next;
    logic                        pin_reg, pin_next;
    logic [bnts_pkg::TPM_W-1:0]  tick_reg, tick_next;
    logic [bnts_pkg::MS_W-1:0]   ms_left_reg, ms_left_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        level_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        done;

    logic [bnts_pkg::TPM_W-1:0]  tpm_eff;
    logic [bnts_pkg::TPM_W-1:0]  tick_inc;
    logic                        ms_wrap;
    logic [bnts_pkg::MS_W-1:0]   ms_dec;
    logic                        ms_end;
    logic [bnts_pkg::MS_W-1:0]   note_ms;
    logic [bnts_pkg::MS_W-1:0]   gap_ext;
    logic                        to_gap;
    logic                        gap_zero;

    assign pop = !empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        tpm_eff  = (ticks_per_ms == '0) ? bnts_pkg::TPM_W'(1) : ticks_per_ms;
        tick_inc = tick_reg + bnts_pkg::TPM_W'(1);
        ms_wrap  = tick_inc >= tpm_eff;
        ms_dec   = (ms_left_reg != '0) ? ms_left_reg - bnts_pkg::MS_W'(1) : ms_left_reg;
        ms_end   = ms_wrap && (ms_dec == '0);
        note_ms  = bnts_pkg::MS_W'(head.beats) * bnts_pkg::MS_W'(beat_ms);
        gap_ext  = bnts_pkg::MS_W'(gap_ms);
        gap_zero = (gap_ms == '0);
        to_gap   = (head.beats == '0) || (note_ms == '0);
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (head.is_note == bnts_pkg::OP_NOTE)
        begin
            if (to_gap)
            begin
                phase_next = gap_zero ? bnts_pkg::PH_IDLE : bnts_pkg::PH_GAP;
            end
            else
            begin
                phase_next = bnts_pkg::PH_NOTE;
            end
        end
        else
        begin
            case (phase_reg)
                bnts_pkg::PH_NOTE:
                begin
                    if (ms_end)
                    begin
                        phase_next = gap_zero ? bnts_pkg::PH_IDLE : bnts_pkg::PH_GAP;
                    end
                end
                bnts_pkg::PH_GAP:
                begin
                    if (ms_end)
                    begin
                        phase_next = bnts_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = bnts_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        half_reload_next = half_reload_reg;
        half_cnt_next    = half_cnt_reg;
        sounding_next    = sounding_reg;
        pin_next         = pin_reg;
        tick_next        = tick_reg;
        ms_left_next     = ms_left_reg;
        done             = 1'b0;
        if (head.is_note == bnts_pkg::OP_NOTE)
        begin
            pin_next  = 1'b1;
            tick_next = '0;
            if (head.freq_nz)
            begin
                half_reload_next = head.half;
                half_cnt_next    = head.half;
            end
            else
            begin
                half_cnt_next = half_reload_reg;
            end
            if (to_gap)
            begin
                sounding_next = 1'b0;
                ms_left_next  = gap_ext;
                done          = gap_zero;
            end
            else
            begin
                sounding_next = head.freq_nz;
                ms_left_next  = note_ms;
            end
        end
        else
        begin
            case (phase_reg)
                bnts_pkg::PH_NOTE:
                begin
                    if (sounding_reg)
                    begin
                        if (half_cnt_reg > bnts_pkg::HALF_W'(1))
                        begin
                            half_cnt_next = half_cnt_reg - bnts_pkg::HALF_W'(1);
                        end
                        else
                        begin
                            half_cnt_next = half_reload_reg;
                            pin_next      = !pin_reg;
                        end
                    end
                    if (ms_wrap)
                    begin
                        tick_next    = '0;
                        ms_left_next = ms_dec;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                    if (ms_end)
                    begin
                        sounding_next = 1'b0;
                        pin_next      = 1'b1;
                        ms_left_next  = gap_ext;
                        done          = gap_zero;
                    end
                end
                bnts_pkg::PH_GAP:
                begin
                    if (ms_wrap)
                    begin
                        tick_next    = '0;
                        ms_left_next = ms_dec;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                    done = ms_end;
                end
                default:
                begin
                    tick_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= bnts_pkg::PH_IDLE;
            half_reload_reg <= '0;
            half_cnt_reg    <= '0;
            sounding_reg    <= 1'b0;
            pin_reg         <= 1'b1;
            tick_reg        <= '0;
            ms_left_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg       <= phase_next;
                half_reload_reg <= half_reload_next;
                half_cnt_reg    <= half_cnt_next;
                sounding_reg    <= sounding_next;
                pin_reg         <= pin_next;
                tick_reg        <= tick_next;
                ms_left_reg     <= ms_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            level_reg <= pin_next;
            busy_reg  <= (phase_next != bnts_pkg::PH_IDLE);
            done_reg  <= done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign buzzer_level = level_reg;
    assign busy_res     = busy_reg;
    assign note_done    = done_reg;

endmodule

`default_nettype wire

/* hdl/buzzer_note_tone_sequencer.sv */
// ----------------------------------------------------------------------------
// buzzer_note_tone_sequencer
// Plays one note at a time on an active-low buzzer from a stream of tick and
// note command words.
//
// The input channel takes one word per accepted handshake: a tick (opcode 0)
// or a note command (opcode 1) with frequency and beat count. The output
// channel returns exactly one result word per input word, in order: the pin
// level, a busy flag and a note-done pulse.
// Ticks and rest notes (frequency zero) enter at one word per cycle while the
// queue is not full. A tone note runs a one bit per cycle serial divider for
// the half period, so the front stalls the input while the divider runs and
// until the note command is pushed into the queue. The command queue lets the
// back keep working while the divider runs.
// Reset clears the sequencer to idle with the pin high and loads the
// register defaults. When the receiver stalls, the result word holds, the
// queue fills and in_stall rises. Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle; the user must keep to this,
// as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module buzzer_note_tone_sequencer #(
    parameter int QUEUE_DEPTH = bnts_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bnts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bnts_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              opcode,
    input  wire logic [bnts_pkg::FREQ_W-1:0]       note_freq,
    input  wire logic [bnts_pkg::BEATS_W-1:0]      note_beats,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   buzzer_level,
    output logic                                   busy_res,
    output logic                                   note_done
);

    logic [bnts_pkg::NUM_W-1:0]   num_cfg_reg;
    logic [bnts_pkg::TEMPO_W-1:0] tempo_cfg_reg;
    logic [bnts_pkg::GAP_W-1:0]   gap_cfg_reg;
    logic [bnts_pkg::TPM_W-1:0]   tpm_cfg_reg;

    bnts_pkg::queue_push_t push;
    bnts_pkg::tone_cmd_t   head;
    logic                  q_empty;
    logic                  q_full;
    logic                  q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cfg_reg   <= bnts_pkg::NUM_RESET;
            tempo_cfg_reg <= bnts_pkg::TEMPO_RESET;
            gap_cfg_reg   <= bnts_pkg::GAP_RESET;
            tpm_cfg_reg   <= bnts_pkg::TPM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bnts_pkg::REG_NUMERATOR: num_cfg_reg   <= cfg_data[bnts_pkg::NUM_W-1:0];
                bnts_pkg::REG_TEMPO:     tempo_cfg_reg <= cfg_data[bnts_pkg::TEMPO_W-1:0];
                bnts_pkg::REG_GAP:       gap_cfg_reg   <= cfg_data[bnts_pkg::GAP_W-1:0];
                bnts_pkg::REG_TPM:       tpm_cfg_reg   <= cfg_data[bnts_pkg::TPM_W-1:0];
                default:                 tpm_cfg_reg   <= tpm_cfg_reg;
            endcase
        end
    end

    bnts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .note_freq  (note_freq),
        .note_beats (note_beats),
        .numerator  (num_cfg_reg),
        .queue_full (q_full),
        .push_o     (push)
    );

    bnts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_i (push),
        .pop    (q_pop),
        .head   (head),
        .empty  (q_empty),
        .full   (q_full)
    );

    bnts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (q_empty),
        .pop          (q_pop),
        .beat_ms      (tempo_cfg_reg),
        .gap_ms       (gap_cfg_reg),
        .ticks_per_ms (tpm_cfg_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .buzzer_level (buzzer_level),
        .busy_res     (busy_res),
        .note_done    (note_done)
    );

endmodule

`default_nettype wire

/* hdl/bnts_checker.sv */
// ----------------------------------------------------------------------------
// bnts_checker
// Port-level checks of the buzzer note tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bnts_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          opcode,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic                          buzzer_level,
    input wire logic                          busy_res,
    input wire logic                          note_done
);

    // A word that ends a note sequence always leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && note_done |-> !busy_res)
        else $error("note_done reported while still busy");

    // The buzzer is off whenever the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> buzzer_level)
        else $error("buzzer driven while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(buzzer_level)
            && $stable(busy_res) && $stable(note_done))
        else $error("stalled result word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(opcode))
        else $error("stalled input word changed");

endmodule

bind buzzer_note_tone_sequencer bnts_checker u_bnts_checker (.*);

`default_nettype wire
